// ===== hdl/cbps_pkg.sv =====
// Package for the cost-based path selector: path codes, operation codes,
// configuration register indexes and shared widths. No dependencies.
package cbps_pkg;

    localparam int MAX_PEERS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int LAT_W      = 32;
    localparam int PEER_W     = 8;
    localparam int OFFSET_W   = 32;
    localparam int PEERS_W    = 7;
    localparam int WINDOW_W   = 16;
    localparam int MIB_SHIFT  = 20;
    localparam int NUM_PATHS  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Latency average: (old * EWMA_MULT + sample) >> EWMA_SHIFT.
    localparam int EWMA_MULT  = 7;
    localparam int EWMA_SHIFT = 3;

    typedef enum logic [1:0] {
        PATH_DEV  = 2'd0,
        PATH_IPC  = 2'd1,
        PATH_RDMA = 2'd2
    } t_path;

    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PEERS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

endpackage

// ===== hdl/cbps_row_mem.sv =====
// Per-peer state memory: one row per peer holding count and latency of all paths.
// Rows never written read as zero through one valid bit per row. Uses cbps_pkg.
module cbps_row_mem
    import cbps_pkg::*;
#(
    parameter int DEPTH = MAX_PEERS_DEF,
    parameter int ROW_W = NUM_PATHS * (COUNT_BITS_DEF + LAT_W)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [ROW_W-1:0]                      o_rd_row,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]                      i_wr_row
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/cbps_mul_unit.sv =====
// Shared multiplier with a registered product, used for the path costs and
// for the latency average. Uses cbps_pkg.
module cbps_mul_unit
    import cbps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [LAT_W-1:0]              i_a,
    input  logic [COUNT_BITS-1:0]         i_b,
    output logic [LAT_W+COUNT_BITS-1:0]   o_prod
);

    logic [LAT_W+COUNT_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (LAT_W + COUNT_BITS)'(i_a) * (LAT_W + COUNT_BITS)'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/cbps_seq.sv =====
// Sequencer of the path selector: takes a transaction, steps the shared
// multiplier over the paths, picks the path and writes the peer row back.
// Uses cbps_pkg; drives cbps_row_mem and cbps_mul_unit from the top level.
module cbps_seq
    import cbps_pkg::*;
#(
    parameter int MAX_PEERS  = MAX_PEERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    output logic                                        o_busy,
    input  logic                                        i_operation,
    input  logic [PEER_W-1:0]                           i_peer,
    input  logic                                        i_same_host,
    input  logic [OFFSET_W-1:0]                         i_dest_offset,
    input  logic [OFFSET_W-1:0]                         i_byte_count,
    input  logic [1:0]                                  i_done_path,
    input  logic [LAT_W-1:0]                            i_latency_sample,
    input  logic [PEERS_W-1:0]                          i_peers_in_use,
    input  logic [WINDOW_W-1:0]                         i_window_mib,
    output logic                                        o_rd_en,
    output logic [(MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1)-1:0] o_rd_addr,
    input  logic [NUM_PATHS*(COUNT_BITS+LAT_W)-1:0]     i_rd_row,
    output logic                                        o_wr_en,
    output logic [(MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1)-1:0] o_wr_addr,
    output logic [NUM_PATHS*(COUNT_BITS+LAT_W)-1:0]     o_wr_row,
    output logic                                        o_mul_en,
    output logic [LAT_W-1:0]                            o_mul_a,
    output logic [COUNT_BITS-1:0]                       o_mul_b,
    input  logic [LAT_W+COUNT_BITS-1:0]                 i_mul_prod,
    output logic                                        o_result_valid,
    output logic [1:0]                                  o_chosen_path,
    output logic                                        o_window_fallback
);

    localparam int IDX_W  = MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1;
    localparam int ENT_W  = COUNT_BITS + LAT_W;
    localparam int ROW_W  = NUM_PATHS * ENT_W;
    localparam int PROD_W = LAT_W + COUNT_BITS;
    localparam int END_W  = OFFSET_W + 1;
    localparam int WEND_W = WINDOW_W + MIB_SHIFT;
    localparam logic [PEER_W:0] PEER_LIMIT = (PEER_W + 1)'(MAX_PEERS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_ACC   = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic                r_local, n_local;
    logic                r_in_range, n_in_range;
    logic [IDX_W-1:0]    r_peer_idx, n_peer_idx;
    t_path               r_path, n_path;
    t_path               r_choice, n_choice;
    logic [END_W-1:0]    r_end, n_end;
    logic [LAT_W-1:0]    r_sample, n_sample;
    logic [PROD_W-1:0]   r_best, n_best;
    logic [LAT_W-1:0]    r_lat_new, n_lat_new;
    logic                r_res_valid, n_res_valid;
    t_path               r_res_path, n_res_path;
    logic                r_res_fb, n_res_fb;

    logic                    accept;
    logic                    in_range;
    logic [COUNT_BITS-1:0]   row_cnt [NUM_PATHS];
    logic [LAT_W-1:0]        row_lat [NUM_PATHS];
    logic [PROD_W:0]         ewma_sum;
    logic                    fallback;
    t_path                   final_path;
    logic [ROW_W-1:0]        wr_row;

    assign accept   = i_start && (r_state == S_IDLE);
    assign in_range = ({1'b0, i_peer} < (PEER_W + 1)'(i_peers_in_use)) &&
                      ({1'b0, i_peer} < PEER_LIMIT);

    always_comb begin
        for (int k = 0; k < NUM_PATHS; k++) begin
            row_cnt[k] = i_rd_row[k*ENT_W +: COUNT_BITS];
            row_lat[k] = i_rd_row[k*ENT_W + COUNT_BITS +: LAT_W];
        end
    end

    // The multiplier sees the latency of the path under evaluation, times its
    // count for a cost or times the averaging weight for a completion.
    assign o_mul_en = (r_state == S_MUL);
    assign o_mul_a  = row_lat[r_path];
    assign o_mul_b  = (r_op == OP_COMPLETE) ? COUNT_BITS'(EWMA_MULT) : row_cnt[r_path];

    assign ewma_sum = {1'b0, i_mul_prod} + (PROD_W + 1)'(r_sample);

    assign fallback = (r_op == OP_REQUEST) && r_in_range && r_local &&
                      (r_choice == PATH_DEV) && (i_window_mib != '0) &&
                      (WEND_W'(r_end) > {i_window_mib, MIB_SHIFT'(0)});
    assign final_path = fallback ? PATH_IPC : r_choice;

    always_comb begin
        wr_row = i_rd_row;
        for (int k = 0; k < NUM_PATHS; k++) begin
            if (r_op == OP_REQUEST) begin
                if ((2'(k) == final_path) && (row_cnt[k] != '1)) begin
                    wr_row[k*ENT_W +: COUNT_BITS] = row_cnt[k] + COUNT_BITS'(1);
                end
            end else if (2'(k) == r_choice) begin
                if (row_cnt[k] != '0) begin
                    wr_row[k*ENT_W +: COUNT_BITS] = row_cnt[k] - COUNT_BITS'(1);
                end
                wr_row[k*ENT_W + COUNT_BITS +: LAT_W] = r_lat_new;
            end
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = i_peer[IDX_W-1:0];
    assign o_wr_en   = (r_state == S_WRITE) && r_in_range;
    assign o_wr_addr = r_peer_idx;
    assign o_wr_row  = wr_row;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_local     = r_local;
        n_in_range  = r_in_range;
        n_peer_idx  = r_peer_idx;
        n_path      = r_path;
        n_choice    = r_choice;
        n_end       = r_end;
        n_sample    = r_sample;
        n_best      = r_best;
        n_lat_new   = r_lat_new;
        n_res_valid = 1'b0;
        n_res_path  = r_res_path;
        n_res_fb    = r_res_fb;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_operation;
                    n_local    = i_same_host;
                    n_in_range = in_range;
                    n_peer_idx = i_peer[IDX_W-1:0];
                    n_end      = END_W'(i_dest_offset) + END_W'(i_byte_count);
                    n_sample   = i_latency_sample;
                    if (i_operation == OP_COMPLETE) begin
                        if (in_range && (i_done_path <= 2'(PATH_RDMA))) begin
                            n_path  = t_path'(i_done_path);
                            n_state = S_MUL;
                        end
                    end else if (!in_range) begin
                        n_choice = PATH_DEV;
                        n_state  = S_WRITE;
                    end else if (!i_same_host) begin
                        n_choice = PATH_RDMA;
                        n_state  = S_WRITE;
                    end else begin
                        n_path   = PATH_IPC;
                        n_choice = PATH_IPC;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_op == OP_COMPLETE) begin
                    n_lat_new = ewma_sum[LAT_W+EWMA_SHIFT-1:EWMA_SHIFT];
                    n_choice  = r_path;
                    n_state   = S_WRITE;
                end else begin
                    // Costs go in the order IPC, device, RDMA; only a strictly
                    // lower cost displaces the earlier path, which gives the
                    // tie order.
                    case (r_path)
                        PATH_IPC: begin
                            n_best  = i_mul_prod;
                            n_path  = PATH_DEV;
                            n_state = S_MUL;
                        end
                        PATH_DEV: begin
                            if (i_mul_prod < r_best) begin
                                n_best   = i_mul_prod;
                                n_choice = PATH_DEV;
                            end
                            n_path  = PATH_RDMA;
                            n_state = S_MUL;
                        end
                        PATH_RDMA: begin
                            if (i_mul_prod < r_best) begin
                                n_choice = PATH_RDMA;
                            end
                            n_state = S_WRITE;
                        end
                        default: begin
                            n_state = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                n_res_valid = (r_op == OP_REQUEST);
                n_res_path  = final_path;
                n_res_fb    = fallback;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_local    <= n_local;
        r_in_range <= n_in_range;
        r_peer_idx <= n_peer_idx;
        r_path     <= n_path;
        r_choice   <= n_choice;
        r_end      <= n_end;
        r_sample   <= n_sample;
        r_best     <= n_best;
        r_lat_new  <= n_lat_new;
        r_res_path <= n_res_path;
        r_res_fb   <= n_res_fb;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_result_valid    = r_res_valid;
    assign o_chosen_path     = r_res_path;
    assign o_window_fallback = r_res_fb;

    a_result_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(r_state == S_WRITE))
        else $error("result strobe without a write step");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_in_range && (r_state == S_WRITE)))
        else $error("row write for an out-of-range peer");

    a_fallback_is_ipc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_fb) |-> (r_res_path == PATH_IPC))
        else $error("window fallback without IPC choice");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_ACC))
        else $error("multiply step not followed by accumulate step");

    a_out_of_range_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_op == OP_REQUEST) && !r_in_range)
            |=> (r_res_valid && (r_res_path == PATH_DEV) && !r_res_fb))
        else $error("out-of-range request not sent to device path");

endmodule

// ===== hdl/cost_based_path_selector.sv =====
// Cost-based path selector, top level: configuration registers and the
// sequencer, row memory and shared multiplier. Uses cbps_pkg.
//
// A transaction is taken when start is high and busy is low. A local request
// steps three cost products through the one shared multiplier, each with a
// multiply and an accumulate step, then the row write; a completion steps one
// product, then the row write; a remote or out-of-range request goes straight
// to the write step; an ignored completion leaves the block idle. A request gives
// one result on o_chosen_path and o_window_fallback, marked by o_result_valid
// for exactly one cycle; the receiver cannot stall it. Completions give no result.
// Configuration writes are always ready and belong in idle time only.
module cost_based_path_selector
    import cbps_pkg::*;
#(
    parameter int MAX_PEERS  = MAX_PEERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [PEER_W-1:0]     i_peer,
    input  logic                  i_same_host,
    input  logic [OFFSET_W-1:0]   i_dest_offset,
    input  logic [OFFSET_W-1:0]   i_byte_count,
    input  logic [1:0]            i_done_path,
    input  logic [LAT_W-1:0]      i_latency_sample,
    output logic                  o_result_valid,
    output logic [1:0]            o_chosen_path,
    output logic                  o_window_fallback,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1;
    localparam int ROW_W  = NUM_PATHS * (COUNT_BITS + LAT_W);
    localparam int PROD_W = LAT_W + COUNT_BITS;

    logic [PEERS_W-1:0]  r_peers_in_use;
    logic [WINDOW_W-1:0] r_window_mib;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_row;
    logic              mul_en;
    logic [LAT_W-1:0]  mul_a;
    logic [COUNT_BITS-1:0] mul_b;
    logic [PROD_W-1:0] mul_prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peers_in_use <= '0;
            r_window_mib   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PEERS:  r_peers_in_use <= i_cfg_data[PEERS_W-1:0];
                CFG_WINDOW: r_window_mib   <= i_cfg_data[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cbps_seq #(
        .MAX_PEERS  (MAX_PEERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_operation       (i_operation),
        .i_peer            (i_peer),
        .i_same_host       (i_same_host),
        .i_dest_offset     (i_dest_offset),
        .i_byte_count      (i_byte_count),
        .i_done_path       (i_done_path),
        .i_latency_sample  (i_latency_sample),
        .i_peers_in_use    (r_peers_in_use),
        .i_window_mib      (r_window_mib),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_row          (rd_row),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_row          (wr_row),
        .o_mul_en          (mul_en),
        .o_mul_a           (mul_a),
        .o_mul_b           (mul_b),
        .i_mul_prod        (mul_prod),
        .o_result_valid    (o_result_valid),
        .o_chosen_path     (o_chosen_path),
        .o_window_fallback (o_window_fallback)
    );

    cbps_row_mem #(
        .DEPTH (MAX_PEERS),
        .ROW_W (ROW_W)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_row  (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_row  (wr_row)
    );

    cbps_mul_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

endmodule

// ===== tb/cbps_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the cost-based path selector. It mirrors the per-peer in-flight
// counts and latency averages, predicts each request's path and checks results.
// Depends on cbps_pkg.
module cbps_checker
    import cbps_pkg::*;
#(
    parameter int MAX_PEERS  = MAX_PEERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_operation,
    input  logic [PEER_W-1:0]     i_peer,
    input  logic                  i_same_host,
    input  logic [OFFSET_W-1:0]   i_dest_offset,
    input  logic [OFFSET_W-1:0]   i_byte_count,
    input  logic [1:0]            i_done_path,
    input  logic [LAT_W-1:0]      i_latency_sample,
    input  logic                  o_result_valid,
    input  logic [1:0]            o_chosen_path,
    input  logic                  o_window_fallback,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_path path;
        logic  fallback;
    } t_path_pick;

    logic [COUNT_BITS-1:0] inflight_tab [NUM_PATHS][MAX_PEERS];
    logic [LAT_W-1:0]      latency_tab  [NUM_PATHS][MAX_PEERS];
    logic [PEERS_W-1:0]    peers_in_use;
    logic [WINDOW_W-1:0]   window_mib;
    t_path_pick            pick_q [$];
    int                    fails = 0;

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic bit peer_active(input logic [PEER_W-1:0] p);
        int lim;
        lim = (int'(peers_in_use) < MAX_PEERS) ? int'(peers_in_use) : MAX_PEERS;
        return int'(p) < lim;
    endfunction

    // In-flight counts stick at their maximum instead of wrapping.
    function automatic void bump_count(input t_path path, input int idx);
        if (inflight_tab[path][idx] != '1) begin
            inflight_tab[path][idx] = inflight_tab[path][idx] + 1'b1;
        end
    endfunction

    function automatic t_path_pick choose_path(input logic [PEER_W-1:0] p,
                                               input logic local_peer,
                                               input logic [OFFSET_W-1:0] off,
                                               input logic [OFFSET_W-1:0] cnt);
        t_path_pick  pick;
        logic [63:0] dev_cost;
        logic [63:0] ipc_cost;
        logic [63:0] rdma_cost;
        logic [63:0] end_byte;
        logic [63:0] window_bytes;
        int          idx;
        idx           = int'(p);
        pick.path     = PATH_DEV;
        pick.fallback = 1'b0;
        if (!peer_active(p)) begin
            return pick;
        end
        if (!local_peer) begin
            pick.path = PATH_RDMA;
            bump_count(PATH_RDMA, idx);
            return pick;
        end
        dev_cost  = 64'(inflight_tab[PATH_DEV][idx]) * 64'(latency_tab[PATH_DEV][idx]);
        ipc_cost  = 64'(inflight_tab[PATH_IPC][idx]) * 64'(latency_tab[PATH_IPC][idx]);
        rdma_cost = 64'(inflight_tab[PATH_RDMA][idx]) * 64'(latency_tab[PATH_RDMA][idx]);
        if (ipc_cost <= dev_cost && ipc_cost <= rdma_cost) begin
            pick.path = PATH_IPC;
        end else if (dev_cost <= rdma_cost) begin
            pick.path = PATH_DEV;
        end else begin
            pick.path = PATH_RDMA;
        end
        // The end of the put is a full 33-bit sum, so it may pass 4 GiB.
        end_byte     = 64'(off) + 64'(cnt);
        window_bytes = 64'(window_mib) << MIB_SHIFT;
        if (pick.path == PATH_DEV && window_mib != '0 && end_byte > window_bytes) begin
            pick.path     = PATH_IPC;
            pick.fallback = 1'b1;
        end
        bump_count(pick.path, idx);
        return pick;
    endfunction

    function automatic void retire(input logic [PEER_W-1:0] p,
                                   input logic [1:0] dpath,
                                   input logic [LAT_W-1:0] sample);
        logic [63:0] blend;
        int          idx;
        int          pi;
        if (!peer_active(p) || dpath > PATH_RDMA) begin
            return;
        end
        idx = int'(p);
        pi  = int'(dpath);
        if (inflight_tab[pi][idx] != '0) begin
            inflight_tab[pi][idx] = inflight_tab[pi][idx] - 1'b1;
        end
        // Moving average weighted 7/8 toward the old value.
        blend = 64'(latency_tab[pi][idx]) * 64'd7 + 64'(sample);
        latency_tab[pi][idx] = LAT_W'(blend >> 3);
    endfunction

    always @(posedge i_clk) begin
        t_path_pick want;
        t_path_pick fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PATHS; i++) begin
                for (int j = 0; j < MAX_PEERS; j++) begin
                    inflight_tab[i][j] = '0;
                    latency_tab[i][j]  = '0;
                end
            end
            peers_in_use = '0;
            window_mib   = '0;
            pick_q.delete();
        end else begin
            if (o_result_valid) begin
                if (pick_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: path=%0d fb=%0b",
                                              o_chosen_path, o_window_fallback));
                end else begin
                    want = pick_q.pop_front();
                    if (o_chosen_path !== want.path) begin
                        report_mismatch($sformatf("chosen_path got %0d, want %0d",
                                                  o_chosen_path, want.path));
                    end
                    if (o_window_fallback !== want.fallback) begin
                        report_mismatch($sformatf("window_fallback got %0b, want %0b",
                                                  o_window_fallback, want.fallback));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PEERS:  peers_in_use = i_cfg_data[PEERS_W-1:0];
                    CFG_WINDOW: window_mib   = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_operation == OP_COMPLETE) begin
                    retire(i_peer, i_done_path, i_latency_sample);
                end else begin
                    fresh  = choose_path(i_peer, i_same_host, i_dest_offset, i_byte_count);
                    pick_q = {pick_q, fresh};
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pick_q.size();
    end

endmodule

// ===== tb/tb_cost_based_path_selector.sv =====
`timescale 1ns / 1ps
// Top of the path selector testbench: clock, reset, stimulus and verdict.
// Depends on cbps_pkg, cost_based_path_selector and cbps_checker.
module tb_cost_based_path_selector;
    import cbps_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int FLOOD_COUNT  = 40;

    typedef struct packed {
        logic                op;
        logic [PEER_W-1:0]   peer;
        logic                same_host;
        logic [OFFSET_W-1:0] offset;
        logic [OFFSET_W-1:0] count;
        logic [1:0]          done_path;
        logic [LAT_W-1:0]    sample;
    } t_xfer;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  i_operation      = OP_REQUEST;
    logic [PEER_W-1:0]     i_peer           = '0;
    logic                  i_same_host      = 1'b0;
    logic [OFFSET_W-1:0]   i_dest_offset    = '0;
    logic [OFFSET_W-1:0]   i_byte_count     = '0;
    logic [1:0]            i_done_path      = '0;
    logic [LAT_W-1:0]      i_latency_sample = '0;
    logic                  o_result_valid;
    logic [1:0]            o_chosen_path;
    logic                  o_window_fallback;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = CFG_PEERS;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int checker_fails;
    int checker_pending;
    int cycle_count = 0;
    bit idle_on     = 1'b1;

    cost_based_path_selector u_dut (.*);

    cbps_checker u_checker (
        .*,
        .o_fail_count(checker_fails),
        .o_pending   (checker_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly back-to-back, some short gaps and an occasional long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic t_xfer make_request(input logic [PEER_W-1:0] peer, input logic same_host,
                                           input logic [OFFSET_W-1:0] offset,
                                           input logic [OFFSET_W-1:0] count);
        t_xfer x;
        x.op        = OP_REQUEST;
        x.peer      = peer;
        x.same_host = same_host;
        x.offset    = offset;
        x.count     = count;
        x.done_path = 2'($urandom);
        x.sample    = $urandom;
        return x;
    endfunction

    function automatic t_xfer make_completion(input logic [PEER_W-1:0] peer,
                                              input logic [1:0] done_path,
                                              input logic [LAT_W-1:0] sample);
        t_xfer x;
        x.op        = OP_COMPLETE;
        x.peer      = peer;
        x.same_host = 1'($urandom);
        x.offset    = $urandom;
        x.count     = $urandom;
        x.done_path = done_path;
        x.sample    = sample;
        return x;
    endfunction

    // Traffic is concentrated on a few peers so that counts and averages build up.
    function automatic t_xfer random_xfer(input int lim);
        t_xfer x;
        int    r;
        int    hot;
        hot         = (lim < 6) ? lim : 6;
        x.op        = ($urandom_range(0, 99) < 45) ? OP_COMPLETE : OP_REQUEST;
        x.same_host = ($urandom_range(0, 99) < 85);
        x.done_path = ($urandom_range(0, 99) < 95) ? 2'($urandom_range(0, 2)) : 2'd3;
        x.sample    = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 2000) : $urandom;
        case ($urandom_range(0, 3))
            0: begin
                x.offset = $urandom;
                x.count  = $urandom;
            end
            1: begin
                x.offset = $urandom_range(0, 1 << 21);
                x.count  = $urandom_range(0, 1 << 20);
            end
            2: begin
                x.offset = 32'hFFFF_FFFF - $urandom_range(0, 255);
                x.count  = $urandom;
            end
            default: begin
                x.offset = $urandom;
                x.count  = $urandom_range(0, 4096);
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 6 || lim == 0) begin
            x.op        = 1'($urandom);
            x.peer      = 8'($urandom);
            x.done_path = 2'($urandom);
        end else if (r < 75) begin
            x.peer = 8'($urandom_range(0, hot - 1));
        end else if (r < 94) begin
            x.peer = 8'($urandom_range(0, lim - 1));
        end else begin
            x.peer = 8'($urandom_range(0, 255));
        end
        return x;
    endfunction

    task automatic issue(input t_xfer x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_operation      <= x.op;
        i_peer           <= x.peer;
        i_same_host      <= x.same_host;
        i_dest_offset    <= x.offset;
        i_byte_count     <= x.count;
        i_done_path      <= x.done_path;
        i_latency_sample <= x.sample;
        do @(posedge i_clk); while (busy);
    endtask

    // Completions give no result, so the block may still be working once nothing is
    // pending: the extra cycles cover the longest transaction.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge i_clk);
        while (checker_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [PEERS_W-1:0] peers,
                                input logic [WINDOW_W-1:0] window);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PEERS;
        i_cfg_data  <= {9'($urandom), peers};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_WINDOW;
        i_cfg_data  <= window;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [PEERS_W-1:0] peers, input logic [WINDOW_W-1:0] window,
                             input int n_items, input bit with_idle);
        int lim;
        quiesce();
        write_config(peers, window);
        lim     = (int'(peers) < MAX_PEERS_DEF) ? int'(peers) : MAX_PEERS_DEF;
        idle_on = with_idle;
        repeat (n_items) issue(random_xfer(lim));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: four peers, 1 MiB window.
        write_config(7'd4, 16'd1);
        issue(make_request(8'd0, 1'b1, 32'd0, 32'd0));
        issue(make_request(8'd255, 1'b1, $urandom, $urandom));
        issue(make_request(8'd4, 1'b1, 32'd0, 32'd0));
        issue(make_request(8'd3, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(make_completion(8'd0, PATH_IPC, 32'hFFFF_FFFF));
        // Second completion on an empty count must not wrap it.
        issue(make_completion(8'd0, PATH_IPC, 32'd0));
        issue(make_completion(8'd1, 2'd3, 32'd5));
        issue(make_completion(8'd200, PATH_DEV, 32'd77));
        issue(make_request(8'd2, 1'b1, 32'd0, 32'd0));
        issue(make_request(8'd2, 1'b1, 32'd0, 32'd0));
        issue(make_completion(8'd2, PATH_IPC, 32'd800));
        // An end exactly at the window edge stays on device; one byte more moves to IPC.
        issue(make_request(8'd2, 1'b1, 32'd0, 32'h0010_0000));
        issue(make_request(8'd2, 1'b1, 32'd1, 32'h0010_0000));
        issue(make_request(8'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(make_completion(8'd2, PATH_DEV, 32'd4000));
        issue(make_request(8'd2, 1'b1, 32'd0, 32'd0));
        issue(make_request(8'd2, 1'b1, 32'd0, 32'd0));
        issue(make_completion(8'd3, PATH_RDMA, 32'hFFFF_FFFF));
        issue(make_request(8'd1, 1'b1, 32'd0, 32'd0));
        issue(make_completion(8'd0, PATH_DEV, 32'hFFFF_FFFF));

        // Pile up one peer's RDMA count, then work on that peer.
        quiesce();
        write_config(7'd64, 16'd0);
        idle_on = 1'b0;
        repeat (FLOOD_COUNT) issue(make_request(8'd63, 1'b0, $urandom, $urandom));
        idle_on = 1'b1;
        repeat (15) begin
            issue(make_request(8'd63, 1'($urandom), $urandom, $urandom));
            issue(make_completion(8'd63, 2'($urandom_range(0, 2)), $urandom_range(0, 5000)));
        end

        run_phase(7'd64, 16'd0, 300, 1'b1);
        run_phase(7'd127, 16'd4096, 250, 1'b0);
        run_phase(7'd8, 16'd1, 300, 1'b1);
        run_phase(7'd3, 16'd65535, 300, 1'b1);
        run_phase(7'd1, 16'd200, 200, 1'b0);
        run_phase(7'd0, 16'd0, 60, 1'b1);

        quiesce();
        if (checker_fails == 0 && checker_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
